/* hw/rtl/lkvc_pkg.sv */
`default_nettype none

package lkvc_pkg;

  // Number of physical entry slots.
  localparam int MAX_ENTRIES = 16;

  // Slot index, occupancy and capacity register widths.
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Request operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Value returned by a get that misses.
  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  // Input request payload.
  typedef struct packed {
    logic               operation;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
  } lkvc_req_t;

  // Result payload.
  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
  } lkvc_rsp_t;

  // One word of the entry memory.
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lkvc_entry_t;

  // Commands from the sequencer to the recency tracker.
  typedef struct packed {
    logic             touch;
    logic             evict;
    logic             insert;
    logic [IDX_W-1:0] slot;
  } lkvc_cmd_t;

  // Status from the recency tracker to the sequencer.
  typedef struct packed {
    logic [MAX_ENTRIES-1:0] valid;
    logic [OCC_W-1:0]       occupancy;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
  } lkvc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/lkvc_store.sv */
`default_nettype none

module lkvc_store (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [lkvc_pkg::IDX_W-1:0]  waddr_i,
  input  wire lkvc_pkg::lkvc_entry_t       wdata_i,
  input  wire logic [lkvc_pkg::IDX_W-1:0]  raddr_i,
  output lkvc_pkg::lkvc_entry_t            rdata_o
);

  lkvc_pkg::lkvc_entry_t mem_q [lkvc_pkg::MAX_ENTRIES];
  lkvc_pkg::lkvc_entry_t rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/lkvc_recency.sv */
`default_nettype none

module lkvc_recency (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lkvc_pkg::lkvc_cmd_t    cmd_i,
  output lkvc_pkg::lkvc_status_t      status_o
);

  logic [lkvc_pkg::MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [lkvc_pkg::IDX_W-1:0]       rank_q [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::IDX_W-1:0]       rank_d [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::OCC_W-1:0]       occ_q, occ_d;
  logic [lkvc_pkg::IDX_W-1:0]       slot_rank;
  logic [lkvc_pkg::IDX_W-1:0]       oldest_rank;
  logic                             free_found;
  logic [lkvc_pkg::IDX_W-1:0]       free_idx;

  // Ranks among valid entries are dense, so the oldest has rank occupancy-1.
  assign slot_rank   = rank_q[cmd_i.slot];
  assign oldest_rank = lkvc_pkg::IDX_W'(occ_q - lkvc_pkg::OCC_W'(1));

  // Update of all valid bits, ranks and the occupancy count for one command.
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    occ_d   = occ_q;
    if (cmd_i.touch) begin
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] < slot_rank)) begin
          rank_d[i] = rank_q[i] + lkvc_pkg::IDX_W'(1);
        end
      end
      rank_d[cmd_i.slot] = '0;
    end else if (cmd_i.evict) begin
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] == oldest_rank)) begin
          valid_d[i] = 1'b0;
          rank_d[i]  = '0;
        end
      end
      if (occ_q != '0) begin
        occ_d = occ_q - lkvc_pkg::OCC_W'(1);
      end
    end else if (cmd_i.insert) begin
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + lkvc_pkg::IDX_W'(1);
        end
      end
      valid_d[cmd_i.slot] = 1'b1;
      rank_d[cmd_i.slot]  = '0;
      occ_d               = occ_q + lkvc_pkg::OCC_W'(1);
    end
  end

  // Lowest-numbered free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = lkvc_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = lkvc_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      rank_q  <= rank_d;
    end
  end

  assign status_o.valid      = valid_q;
  assign status_o.occupancy  = occ_q;
  assign status_o.free_found = free_found;
  assign status_o.free_idx   = free_idx;

endmodule

`default_nettype wire

/* hw/rtl/lru_key_value_cache_core.sv */
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        request    in_valid_i / in_stall_o   in_req_i  (lkvc_req_t)
// out       result     out_valid_o / out_stall_i out_rsp_o (lkvc_rsp_t)
// cfg       write      cfg_we_i                  cfg_wdata_i (capacity)
//
// A get or a put to a present key is accepted, scans every slot for the key through
// the single entry memory read port and its one comparator, then resolves. A put of
// a new key then evicts the least recent entry, one at a time, until it sees that
// there is room, and then inserts.
// Reset clears all valid marks, ranks and occupancy at once; no clearing pass.
// A get waits in its resolve cycle while the previous result is still stalled.
// Only a get produces a result; a put produces none.

module lru_key_value_cache_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lkvc_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire lkvc_pkg::lkvc_req_t               in_req_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output lkvc_pkg::lkvc_rsp_t                    out_rsp_o
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_RESOLVE = 5'b00100,
    ST_EVICT   = 5'b01000,
    ST_INSERT  = 5'b10000
  } state_e;

  state_e                         state_q, state_d;
  logic [lkvc_pkg::OCC_W-1:0]     cnt_q, cnt_d;
  logic [lkvc_pkg::CAP_W-1:0]     cap_q;
  lkvc_pkg::lkvc_req_t            req_q;
  logic                           hit_q, hit_d;
  logic [lkvc_pkg::IDX_W-1:0]     hit_idx_q;
  logic signed [31:0]             hit_val_q;
  logic                           out_valid_q, out_valid_d;
  lkvc_pkg::lkvc_rsp_t            out_q, out_d;

  logic                           mem_we;
  logic [lkvc_pkg::IDX_W-1:0]     mem_waddr;
  lkvc_pkg::lkvc_entry_t          mem_wdata;
  lkvc_pkg::lkvc_entry_t          mem_rdata;
  lkvc_pkg::lkvc_cmd_t            cmd;
  lkvc_pkg::lkvc_status_t         status;

  logic [lkvc_pkg::IDX_W-1:0]     cmp_idx;
  logic                           match;
  logic                           accept;
  logic [lkvc_pkg::CMP_W-1:0]     cap_ext, eff_cap, occ_ext;

  lkvc_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (cnt_q[lkvc_pkg::IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  lkvc_recency u_recency (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status)
  );

  assign accept = in_valid_i && !in_stall_o;

  // Shared key comparator: checks the entry read in the previous scan cycle.
  assign cmp_idx = lkvc_pkg::IDX_W'(cnt_q - lkvc_pkg::OCC_W'(1));
  assign match   = (state_q == ST_SCAN) && (cnt_q != '0) && status.valid[cmp_idx] &&
                   (mem_rdata.key == req_q.lookup_key);

  // Effective capacity, clamped to one..MAX_ENTRIES.
  always_comb begin
    cap_ext = lkvc_pkg::CMP_W'(cap_q);
    occ_ext = lkvc_pkg::CMP_W'(status.occupancy);
    if (cap_ext == '0) begin
      eff_cap = lkvc_pkg::CMP_W'(1);
    end else if (cap_ext > lkvc_pkg::CMP_W'(lkvc_pkg::MAX_ENTRIES)) begin
      eff_cap = lkvc_pkg::CMP_W'(lkvc_pkg::MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = hit_idx_q;
    mem_wdata   = '{key: req_q.lookup_key, value: req_q.store_value};
    cmd         = '{touch: 1'b0, evict: 1'b0, insert: 1'b0, slot: hit_idx_q};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          hit_d = 1'b1;
        end
        cnt_d = cnt_q + lkvc_pkg::OCC_W'(1);
        if (cnt_q == lkvc_pkg::OCC_W'(lkvc_pkg::MAX_ENTRIES)) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (req_q.operation == lkvc_pkg::OP_GET) begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_d      = 1'b1;
            out_d.found      = hit_q;
            out_d.read_value = hit_q ? hit_val_q : lkvc_pkg::MISS_VALUE;
            cmd.touch        = hit_q;
            state_d          = ST_IDLE;
          end
        end else if (hit_q) begin
          mem_we    = 1'b1;
          cmd.touch = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (occ_ext >= eff_cap) begin
          cmd.evict = 1'b1;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (status.free_found) begin
          mem_we     = 1'b1;
          mem_waddr  = status.free_idx;
          cmd.insert = 1'b1;
          cmd.slot   = status.free_idx;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= lkvc_pkg::CAP_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (match && !hit_q) begin
      hit_idx_q <= cmp_idx;
      hit_val_q <= mem_rdata.value;
    end
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The valid count always equals the occupancy counter.
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(status.valid) == int'(status.occupancy))
    else $error("occupancy counter disagrees with valid marks");

  // The entry memory is never written during the key scan.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we)
    else $error("entry memory written during scan");

  // A new result appears only after a resolve cycle.
  a_result_from_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RESOLVE))
    else $error("result raised outside resolve");

  // An insert never pushes occupancy past the clamped capacity.
  a_insert_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> (occ_ext < eff_cap))
    else $error("insert with store full");

endmodule

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;

  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 56;
  localparam int KEY_POOL_SIZE = 24;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  lkvc_pkg::lkvc_req_t        in_req_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  lkvc_pkg::lkvc_rsp_t        out_rsp_o;

  lru_key_value_cache_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Shadow copy of the cache contents and the capacity register.
  logic                       slot_used  [lkvc_pkg::MAX_ENTRIES];
  logic signed [31:0]         slot_key   [lkvc_pkg::MAX_ENTRIES];
  logic signed [31:0]         slot_value [lkvc_pkg::MAX_ENTRIES];
  int unsigned                slot_age   [lkvc_pkg::MAX_ENTRIES];
  int unsigned                used_count;
  logic [lkvc_pkg::CAP_W-1:0] cap_reg = lkvc_pkg::CAP_RESET;

  // Lookup results still owed by the block, oldest first.
  lkvc_pkg::lkvc_rsp_t        pending_lookups[$];
  lkvc_pkg::lkvc_rsp_t        oldest_lookup;

  logic [31:0]                key_pool [KEY_POOL_SIZE];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int error_count   = 0;
  int request_count = 0;
  int get_count     = 0;
  int hit_count     = 0;
  int cap_writes    = 0;
  int cycle_count   = 0;

  // Free-running clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Make slot s the most recent one; younger entries age by one.
  function automatic void promote_slot(input int s);
    int unsigned r;
    r = slot_age[s];
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++)
      if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Apply one accepted request to the shadow cache and queue its lookup result.
  function automatic void model_request(input lkvc_pkg::lkvc_req_t req);
    int hit;
    int lim;
    int oldest;
    int free_slot;
    int unsigned oldest_age;
    hit = -1;
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++)
      if (hit < 0 && slot_used[i] && slot_key[i] == req.lookup_key) hit = i;

    if (req.operation == lkvc_pkg::OP_GET) begin
      get_count++;
      if (hit >= 0) begin
        promote_slot(hit);
        hit_count++;
        pending_lookups.push_back(lkvc_pkg::lkvc_rsp_t'{found: 1'b1,
                                                        read_value: slot_value[hit]});
      end else begin
        pending_lookups.push_back(lkvc_pkg::lkvc_rsp_t'{found: 1'b0,
                                                        read_value: lkvc_pkg::MISS_VALUE});
      end
      return;
    end

    // A put to a present key only updates and refreshes the entry.
    if (hit >= 0) begin
      slot_value[hit] = req.store_value;
      promote_slot(hit);
      return;
    end

    // A new key evicts the least recent entries until there is room.
    lim = (cap_reg == 0) ? 1 : ((cap_reg > lkvc_pkg::MAX_ENTRIES) ? lkvc_pkg::MAX_ENTRIES
                                                                  : int'(cap_reg));
    while (used_count >= lim && used_count > 0) begin
      oldest = -1;
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++)
        if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
      oldest_age = slot_age[oldest];
      slot_used[oldest] = 1'b0;
      slot_age[oldest] = 0;
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++)
        if (slot_used[i] && slot_age[i] > oldest_age) slot_age[i]--;
      used_count--;
    end

    free_slot = -1;
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++)
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    if (free_slot < 0) return;
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_used[free_slot]  = 1'b1;
    slot_key[free_slot]   = req.lookup_key;
    slot_value[free_slot] = req.store_value;
    slot_age[free_slot]   = 0;
    used_count++;
  endfunction

  // Present one request, optionally after a random gap, and wait for its acceptance.
  task automatic send_request(input lkvc_pkg::lkvc_req_t req);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do begin
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    model_request(req);
    request_count++;
  endtask

  task automatic put_entry(input logic [31:0] key, input logic [31:0] value);
    send_request(lkvc_pkg::lkvc_req_t'{operation: lkvc_pkg::OP_PUT, lookup_key: key,
                                       store_value: value});
  endtask

  task automatic get_entry(input logic [31:0] key);
    send_request(lkvc_pkg::lkvc_req_t'{operation: lkvc_pkg::OP_GET, lookup_key: key,
                                       store_value: $urandom});
  endtask

  // Wait until every lookup has returned and any trailing put has finished.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cap_reg = cap;
    cap_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // Check each delivered lookup result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result found=%0b read_value=%h",
                 $time, out_rsp_o.found, out_rsp_o.read_value);
        error_count++;
      end else begin
        oldest_lookup = pending_lookups.pop_front();
        if (out_rsp_o.found !== oldest_lookup.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, oldest_lookup.found, out_rsp_o.found);
          error_count++;
        end
        if (out_rsp_o.read_value !== oldest_lookup.read_value) begin
          $display("%0t: read_value mismatch, expected %h, actual %h",
                   $time, oldest_lookup.read_value, out_rsp_o.read_value);
          error_count++;
        end
      end
    end
  end

  // Lookups on an empty store, extreme keys and values, and an in-place update.
  task automatic test_lookup_extremes();
    set_capacity(5'd31);
    get_entry(32'h8000_0000);
    put_entry(32'h8000_0000, 32'h7fff_ffff);
    put_entry(32'h7fff_ffff, 32'h8000_0000);
    put_entry(32'h0000_0000, 32'h0000_0000);
    put_entry(32'hffff_ffff, 32'hffff_ffff);
    get_entry(32'h8000_0000);
    get_entry(32'h7fff_ffff);
    get_entry(32'hffff_ffff);
    put_entry(32'h0000_0000, 32'h5555_aaaa);
    get_entry(32'h0000_0000);
    get_entry(32'h0000_0001);
  endtask

  // Capacity lowered below the fill level: the next new key evicts several.
  task automatic test_shrink_eviction();
    set_capacity(5'd2);
    put_entry(32'd100, 32'd1);
    get_entry(32'hffff_ffff);
    get_entry(32'h0000_0000);
    get_entry(32'd100);
  endtask

  // Zero capacity behaves as one entry; then plain recency order at three.
  task automatic test_lru_order();
    set_capacity(5'd0);
    put_entry(32'd7, 32'd70);
    get_entry(32'd7);
    put_entry(32'd7, 32'd71);
    get_entry(32'd7);
    put_entry(32'd8, 32'd80);
    get_entry(32'd7);
    set_capacity(5'd3);
    put_entry(32'd1, 32'd10);
    put_entry(32'd2, 32'd20);
    get_entry(32'd8);
    put_entry(32'd3, 32'd30);
    get_entry(32'd1);
    get_entry(32'd2);
  endtask

  function automatic logic [lkvc_pkg::CAP_W-1:0] phase_capacity(input int p);
    case (p)
      0:       return 5'd16;
      1:       return 5'd1;
      2:       return 5'd4;
      3:       return 5'd31;
      4:       return 5'd0;
      5:       return 5'd9;
      6:       return 5'd2;
      default: return 5'd16;
    endcase
  endfunction

  // Random request mostly over a small key pool, so that hits and evictions are common.
  function automatic lkvc_pkg::lkvc_req_t random_request();
    lkvc_pkg::lkvc_req_t req;
    int span;
    span = int'(cap_reg) + 6;
    if (span > KEY_POOL_SIZE) span = KEY_POOL_SIZE;
    req.operation  = $urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
    req.lookup_key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, span - 1)]
                                                 : $urandom;
    if ($urandom_range(0, 9) == 0)
      req.store_value = key_pool[$urandom_range(0, 3)];
    else
      req.store_value = $urandom;
    return req;
  endfunction

  // Random traffic over several capacities and all idle patterns.
  task automatic test_random_traffic();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_capacity(phase_capacity(p));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
    end
  endtask

  // Main sequence.
  initial begin
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
    end
    used_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_lookup_extremes();
    test_shrink_eviction();
    test_lru_order();
    test_random_traffic();
    settle_block();
    $display("Covered %0d requests, %0d of them lookups with %0d hits, over %0d capacity writes.",
             request_count, get_count, hit_count, cap_writes);
    $display("Traffic ran without idling, with sender gaps, receiver stalls and both at once.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
